>>> sv/dfd_pkg.sv
// Package for the ducted-fan derivative block: constants, types, CORDIC arctangent table.
`default_nettype none
package dfd_pkg;
    localparam int TABLE_LEN = 30;
    localparam logic signed [18:0] PI_Q16 = 19'sd205887;
    localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic [1:0] REG_DAMPING = 2'd0;
    localparam logic [1:0] REG_INV_MASS = 2'd1;
    localparam logic [1:0] REG_GRAVITY = 2'd2;
    localparam logic [1:0] REG_ARM = 2'd3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 31;

    typedef logic [30:0] cfg_word_t;
    typedef logic signed [33:0] cvec_t;

    // item travelling beside the CORDIC chain
    typedef struct packed {
        logic        flip;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [13:0] thrust_main;
        logic signed [13:0] thrust_side;
    } side_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_angle;
    } result_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        r = '0;
        unique case (i)
            5'd0: r = 34'sh03243F6A8; 5'd1: r = 34'sh01DAC6705;
            5'd2: r = 34'sh00FADBAFC; 5'd3: r = 34'sh007F56EA6;
            5'd4: r = 34'sh003FEAB76; 5'd5: r = 34'sh001FFD55B;
            5'd6: r = 34'sh000FFFAAA; 5'd7: r = 34'sh0007FFF55;
            5'd8: r = 34'sh0003FFFEA; 5'd9: r = 34'sh0001FFFFD;
            5'd10: r = 34'sh000FFFFF; 5'd11: r = 34'sh0007FFFF;
            5'd12: r = 34'sh0003FFFF; 5'd13: r = 34'sh0001FFFF;
            5'd14: r = 34'sh0000FFFF; 5'd15: r = 34'sh00007FFF;
            5'd16: r = 34'sh00003FFF; 5'd17: r = 34'sh00001FFF;
            5'd18: r = 34'sh00000FFF; 5'd19: r = 34'sh000007FF;
            5'd20: r = 34'sh000003FF; 5'd21: r = 34'sh000001FF;
            5'd22: r = 34'sh000000FF; 5'd23: r = 34'sh0000007F;
            5'd24: r = 34'sh0000003F; 5'd25: r = 34'sh0000001F;
            5'd26: r = 34'sh0000000F; 5'd27: r = 34'sh00000008;
            5'd28: r = 34'sh00000004; 5'd29: r = 34'sh00000002;
            default: r = '0;
        endcase
        return r;
    endfunction

    // truncate toward zero after dropping s fraction bits
    function automatic logic signed [79:0] trunc_shift(input logic signed [79:0] v,
                                                         input int s);
        logic signed [79:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        logic signed [31:0] r;
        if (v > 80'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -80'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

>>> sv/dfd_if.sv
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none
interface dfd_in_if;
    logic valid;
    logic ready;
    logic signed [18:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [13:0] thrust_main;
    logic signed [13:0] thrust_side;
    modport source (output valid, heading, vel_x, vel_y, thrust_main, thrust_side,
                    input ready);
    modport sink (input valid, heading, vel_x, vel_y, thrust_main, thrust_side,
                  output ready);
endinterface

interface dfd_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_angle;
    modport source (output valid, accel_x, accel_y, accel_angle, input ready);
    modport sink (input valid, accel_x, accel_y, accel_angle, output ready);
endinterface
`default_nettype wire

>>> sv/dfd_cell.sv
// One CORDIC rotation cell: rotates the vector by one table angle and passes it on.
`default_nettype none
module dfd_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                valid_in,
    input  wire dfd_pkg::cvec_t      x_in,
    input  wire dfd_pkg::cvec_t      y_in,
    input  wire dfd_pkg::cvec_t      z_in,
    input  wire dfd_pkg::side_t      side_in,
    output logic                     valid_out,
    output dfd_pkg::cvec_t           x_out,
    output dfd_pkg::cvec_t           y_out,
    output dfd_pkg::cvec_t           z_out,
    output dfd_pkg::side_t           side_out
);
    import dfd_pkg::*;
    localparam logic [4:0] IDX = 5'(STAGE);
    cvec_t dx, dy, x_next, y_next, z_next;
    logic valid_reg;
    cvec_t x_reg, y_reg, z_reg;
    side_t side_reg;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[33])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan_q30(IDX);
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan_q30(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

>>> sv/dfd_force.sv
// Force and scaling pipeline after the CORDIC chain, with saturation.
`default_nettype none
module dfd_force (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                valid_in,
    input  wire dfd_pkg::cvec_t      cos_in,
    input  wire dfd_pkg::cvec_t      sin_in,
    input  wire dfd_pkg::side_t      side_in,
    input  wire dfd_pkg::cfg_word_t  damping,
    input  wire dfd_pkg::cfg_word_t  inv_mass,
    input  wire dfd_pkg::cfg_word_t  gravity,
    input  wire dfd_pkg::cfg_word_t  arm_over_inertia,
    output logic                     valid_out,
    output dfd_pkg::result_t         result
);
    import dfd_pkg::*;
    // stage 1: products
    logic [3:0] valid_reg;
    logic signed [79:0] dvx_reg, dvy_reg, u1c_reg, u1s_reg, u2c_reg, u2s_reg, aa_reg;
    // stage 2: forces
    logic signed [79:0] fx_reg, fy_reg, aa2_reg;
    // stage 3: mass scaling split into high and low partial products
    logic fx_neg_reg, fy_neg_reg;
    logic [63:0] fxh_reg, fxl_reg, fyh_reg, fyl_reg;
    logic signed [31:0] aa3_reg;
    // stage 4: results
    result_t res_reg;
    cvec_t cs, sn;
    logic signed [79:0] fx_next, fy_next, dvx_next, dvy_next;
    logic signed [79:0] fx_mag, fy_mag;
    logic [31:0] fx_hi, fy_hi;
    logic [15:0] fx_lo, fy_lo;
    logic signed [79:0] ax_mag, ay_mag, ax_full, ay_full;

    always_comb
    begin
        cs = side_in.flip ? -cos_in : cos_in;
        sn = side_in.flip ? -sin_in : sin_in;
        dvx_next = 80'(side_in.vel_x) * $signed({49'd0, damping});
        dvy_next = 80'(side_in.vel_y) * $signed({49'd0, damping});
        fx_next = -trunc_shift(dvx_reg, 16) + trunc_shift(u1c_reg, 30)
                  - trunc_shift(u2s_reg, 30);
        fy_next = -trunc_shift(dvy_reg, 16) + trunc_shift(u1s_reg, 30)
                  + trunc_shift(u2c_reg, 30);
        // |f| stays below 2^47, so 32 high bits and 16 low bits cover it
        fx_mag = fx_reg[79] ? -fx_reg : fx_reg;
        fy_mag = fy_reg[79] ? -fy_reg : fy_reg;
        fx_hi = fx_mag[47:16];
        fx_lo = fx_mag[15:0];
        fy_hi = fy_mag[47:16];
        fy_lo = fy_mag[15:0];
        ax_mag = 80'(fxh_reg) + 80'(fxl_reg >> 16);
        ay_mag = 80'(fyh_reg) + 80'(fyl_reg >> 16);
        ax_full = fx_neg_reg ? -ax_mag : ax_mag;
        ay_full = (fy_neg_reg ? -ay_mag : ay_mag) - $signed({49'd0, gravity});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvx_reg <= dvx_next;
            dvy_reg <= dvy_next;
            u1c_reg <= 80'(side_in.thrust_main) * 80'(cs);
            u1s_reg <= 80'(side_in.thrust_main) * 80'(sn);
            u2c_reg <= 80'(side_in.thrust_side) * 80'(cs);
            u2s_reg <= 80'(side_in.thrust_side) * 80'(sn);
            aa_reg <= 80'(side_in.thrust_main) * $signed({49'd0, arm_over_inertia});
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            aa2_reg <= trunc_shift(aa_reg, 16);
            fx_neg_reg <= fx_reg[79];
            fy_neg_reg <= fy_reg[79];
            fxh_reg <= 64'(fx_hi) * 64'(inv_mass);
            fxl_reg <= 64'(fx_lo) * 64'(inv_mass);
            fyh_reg <= 64'(fy_hi) * 64'(inv_mass);
            fyl_reg <= 64'(fy_lo) * 64'(inv_mass);
            aa3_reg <= sat32(aa2_reg);
            res_reg.accel_x <= sat32(ax_full);
            res_reg.accel_y <= sat32(ay_full);
            res_reg.accel_angle <= aa3_reg;
        end
    end

    assign valid_out = valid_reg[3];
    assign result = res_reg;
endmodule
`default_nettype wire

>>> sv/ducted_fan_derivative.sv
// Top level: config registers, heading reduction, CORDIC cell chain, force pipeline.
//
//  channel | dir | beat
//  in_ch   | in  | heading, vel_x, vel_y, thrust_main, thrust_side
//  out_ch  | out | accel_x, accel_y, accel_angle
//  cfg     | in  | cfg_we, cfg_index, cfg_data (no read-back)
//
// One beat per cycle sustained while the output is taken; path: input
// register, one cell per CORDIC iteration, four force stages, output.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears all valid bits and loads register defaults.
`default_nettype none
module ducted_fan_derivative #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dfd_in_if.sink                             in_ch,
    dfd_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [dfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dfd_pkg::*;
    localparam int N = CORDIC_STAGES;

    cfg_word_t damping_reg, inv_mass_reg, gravity_reg, arm_reg;
    logic en;
    logic in_valid_reg;
    cvec_t z0_reg;
    side_t side0_reg;
    logic signed [18:0] th_red;
    logic flip;

    logic valid_c [0:N];
    cvec_t x_c [0:N];
    cvec_t y_c [0:N];
    cvec_t z_c [0:N];
    side_t side_c [0:N];

    logic f_valid;
    result_t f_res;
    logic out_valid_reg;
    result_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= 31'd6554;
            inv_mass_reg <= 31'd65536;
            gravity_reg <= 31'd642908;
            arm_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_W'(REG_DAMPING)) damping_reg <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_INV_MASS)) inv_mass_reg <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_GRAVITY)) gravity_reg <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_ARM)) arm_reg <= cfg_data;
        end
    end

    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_comb
    begin
        priority if (in_ch.heading > HALF_PI_Q16)
        begin
            th_red = in_ch.heading - PI_Q16;
            flip = 1'b1;
        end
        else if (in_ch.heading < -HALF_PI_Q16)
        begin
            th_red = in_ch.heading + PI_Q16;
            flip = 1'b1;
        end
        else
        begin
            th_red = in_ch.heading;
            flip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg <= {{1{th_red[18]}}, th_red, 14'd0};
            side0_reg.flip <= flip;
            side0_reg.vel_x <= in_ch.vel_x;
            side0_reg.vel_y <= in_ch.vel_y;
            side0_reg.thrust_main <= in_ch.thrust_main;
            side0_reg.thrust_side <= in_ch.thrust_side;
        end
    end

    assign valid_c[0] = in_valid_reg;
    assign x_c[0] = CORDIC_GAIN;
    assign y_c[0] = '0;
    assign z_c[0] = z0_reg;
    assign side_c[0] = side0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        dfd_cell #(.STAGE(i)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(valid_c[i]), .x_in(x_c[i]), .y_in(y_c[i]), .z_in(z_c[i]),
            .side_in(side_c[i]),
            .valid_out(valid_c[i+1]), .x_out(x_c[i+1]), .y_out(y_c[i+1]),
            .z_out(z_c[i+1]), .side_out(side_c[i+1])
        );
    end

    dfd_force u_force (
        .clk(clk), .rst_n(rst_n), .en(en),
        .valid_in(valid_c[N]), .cos_in(x_c[N]), .sin_in(y_c[N]), .side_in(side_c[N]),
        .damping(damping_reg), .inv_mass(inv_mass_reg), .gravity(gravity_reg),
        .arm_over_inertia(arm_reg),
        .valid_out(f_valid), .result(f_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= f_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= f_res;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.accel_x = out_reg.accel_x;
    assign out_ch.accel_y = out_reg.accel_y;
    assign out_ch.accel_angle = out_reg.accel_angle;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result beat changed while stalled");
    a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_valid_reg || out_ch.ready))
        else $error("input ready out of step with output register");
    a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(in_valid_reg))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire
